[rtl/core/af2d_pkg.sv]
// ----------------------------------------------------------------------------
// af2d_pkg
// Types, constants and the rounding helper shared by the 2D affine transform.
// ----------------------------------------------------------------------------
package af2d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int LANES     = 4;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_VECTOR = 2'd1,
		OP_WINDOW = 2'd2,
		OP_RECT   = 2'd3
	} af2d_op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX  = 3'd0,
		REG_COEF_XY  = 3'd1,
		REG_COEF_YX  = 3'd2,
		REG_COEF_YY  = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5
	} af2d_reg_e;

	typedef struct packed {
		af2d_op_e                   opcode;
		logic signed [COORD_W-1:0]  px;
		logic signed [COORD_W-1:0]  py;
		logic signed [COORD_W-1:0]  qx;
		logic signed [COORD_W-1:0]  qy;
		logic                       rect_special;
	} af2d_cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  res_x;
		logic signed [COORD_W-1:0]  res_y;
		logic signed [COORD_W-1:0]  res_x2;
		logic signed [COORD_W-1:0]  res_y2;
		logic                       saturated;
	} af2d_rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  coef_xx;
		logic signed [COORD_W-1:0]  coef_xy;
		logic signed [COORD_W-1:0]  coef_yx;
		logic signed [COORD_W-1:0]  coef_yy;
		logic signed [COORD_W-1:0]  offset_x;
		logic signed [COORD_W-1:0]  offset_y;
	} af2d_cfg_t;

	// stage enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} af2d_en_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  rx;
		logic signed [COORD_W-1:0]  ry;
		logic                       sat;
	} af2d_lane_res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  value;
		logic                       sat;
	} af2d_rnd_t;

	localparam logic signed [COORD_W-1:0] COEF_ONE = COORD_W'(1) << FRAC_BITS;

	// corners: left/top, right/bottom, right/top, left/bottom
	localparam logic [LANES-1:0] CORNER_USE_QX = 4'b0110;
	localparam logic [LANES-1:0] CORNER_USE_QY = 4'b1010;

	localparam logic signed [SUM_W-1:0] NEAR_ADD = (SUM_W'(1) << FRAC_BITS) >> 1;
	localparam logic signed [SUM_W-1:0] CEIL_ADD = (SUM_W'(1) << (2 * FRAC_BITS)) - 1;
	localparam logic signed [SUM_W-1:0] RES_MAX  = (SUM_W'(1) << (COORD_W - 1)) - 1;
	localparam logic signed [SUM_W-1:0] RES_MIN  = -(SUM_W'(1) << (COORD_W - 1));

	function automatic af2d_rnd_t round_sat(input logic signed [SUM_W-1:0] sum,
			input logic ceil_px);
		logic signed [SUM_W-1:0] biased;
		logic signed [SUM_W-1:0] shifted;
		af2d_rnd_t               r;
		biased = sum + (ceil_px ? CEIL_ADD : NEAR_ADD);
		shifted = ceil_px ? (biased >>> (2 * FRAC_BITS)) : (biased >>> FRAC_BITS);
		if (shifted > RES_MAX) begin
			r.value = RES_MAX[COORD_W-1:0];
			r.sat   = 1'b1;
		end else if (shifted < RES_MIN) begin
			r.value = RES_MIN[COORD_W-1:0];
			r.sat   = 1'b1;
		end else begin
			r.value = shifted[COORD_W-1:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/core/af2d_lane.sv]
// ----------------------------------------------------------------------------
// af2d_lane
// One corner of the transform: both rows of the matrix, offset, rounding and
// clamping over three pipeline stages.
// ----------------------------------------------------------------------------
module af2d_lane
	import af2d_pkg::*;
(
	input  logic                       clk,
	input  af2d_en_t                   en,
	input  af2d_cfg_t                  cfg,
	input  logic signed [COORD_W-1:0]  x,
	input  logic signed [COORD_W-1:0]  y,
	input  logic                       use_off,
	input  logic                       ceil_px,
	output af2d_lane_res_t             res
);

	logic signed [PROD_W-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1;
	logic                     use_off_s1, ceil_s1, ceil_s2;
	logic signed [SUM_W-1:0]  sum_x_s2, sum_y_s2;
	logic signed [SUM_W-1:0]  off_x, off_y;
	af2d_rnd_t                rnd_x, rnd_y;
	af2d_lane_res_t           res_s3;

	// products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_xx_s1    <= cfg.coef_xx * x;
			p_xy_s1    <= cfg.coef_xy * y;
			p_yx_s1    <= cfg.coef_yx * x;
			p_yy_s1    <= cfg.coef_yy * y;
			use_off_s1 <= use_off;
			ceil_s1    <= ceil_px;
		end
	end

	always_comb begin
		off_x = use_off_s1 ? (SUM_W'(cfg.offset_x) <<< FRAC_BITS) : '0;
		off_y = use_off_s1 ? (SUM_W'(cfg.offset_y) <<< FRAC_BITS) : '0;
	end

	// exact sums
	always_ff @(posedge clk) begin
		if (en.s2) begin
			sum_x_s2 <= SUM_W'(p_xx_s1) + SUM_W'(p_xy_s1) + off_x;
			sum_y_s2 <= SUM_W'(p_yx_s1) + SUM_W'(p_yy_s1) + off_y;
			ceil_s2  <= ceil_s1;
		end
	end

	always_comb begin
		rnd_x = round_sat(sum_x_s2, ceil_s2);
		rnd_y = round_sat(sum_y_s2, ceil_s2);
	end

	// rounded and clamped
	always_ff @(posedge clk) begin
		if (en.s3) begin
			res_s3.rx  <= rnd_x.value;
			res_s3.ry  <= rnd_y.value;
			res_s3.sat <= rnd_x.sat | rnd_y.sat;
		end
	end

	assign res = res_s3;

endmodule

[rtl/core/af2d_merge.sv]
// ----------------------------------------------------------------------------
// af2d_merge
// Combines the lane results into one result item: bounding box in rect mode,
// lane zero otherwise, pass-through for a special rectangle.
// ----------------------------------------------------------------------------
module af2d_merge
	import af2d_pkg::*;
(
	input  logic                              clk,
	input  af2d_en_t                          en,
	input  af2d_cmd_t                         cmd,
	input  af2d_lane_res_t [LANES-1:0]        lane_res,
	output af2d_rsp_t                         rsp
);

	function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
	logic                      any_sat;
	af2d_rsp_t                 nxt;
	af2d_rsp_t                 rsp_s4;

	always_comb begin
		min_x = smin(smin(lane_res[0].rx, lane_res[1].rx), smin(lane_res[2].rx, lane_res[3].rx));
		max_x = smax(smax(lane_res[0].rx, lane_res[1].rx), smax(lane_res[2].rx, lane_res[3].rx));
		min_y = smin(smin(lane_res[0].ry, lane_res[1].ry), smin(lane_res[2].ry, lane_res[3].ry));
		max_y = smax(smax(lane_res[0].ry, lane_res[1].ry), smax(lane_res[2].ry, lane_res[3].ry));
		any_sat = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat | lane_res[3].sat;

		if (cmd.opcode != OP_RECT) begin
			nxt.res_x     = lane_res[0].rx;
			nxt.res_y     = lane_res[0].ry;
			nxt.res_x2    = '0;
			nxt.res_y2    = '0;
			nxt.saturated = lane_res[0].sat;
		end else if (cmd.rect_special) begin
			nxt.res_x     = cmd.px;
			nxt.res_y     = cmd.py;
			nxt.res_x2    = cmd.qx;
			nxt.res_y2    = cmd.qy;
			nxt.saturated = 1'b0;
		end else begin
			nxt.res_x     = min_x;
			nxt.res_y     = min_y;
			nxt.res_x2    = max_x;
			nxt.res_y2    = max_y;
			nxt.saturated = any_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			rsp_s4 <= nxt;
		end
	end

	assign rsp = rsp_s4;

endmodule

[rtl/core/affine_2d_transform.sv]
// ----------------------------------------------------------------------------
// affine_2d_transform
// 2D affine map of points, vectors, pixel windows and rectangles in Q16.16.
// ----------------------------------------------------------------------------
// Channels: cmd (valid/ready) takes one item per cycle while cmd_ready is
// high; rsp (valid/ready) gives one result item per command item, in order.
// cfg (valid/ready) writes the matrix and offset registers by index;
// cfg_ready is always high, and an index past the last register is ignored.
// Write cfg only while no item is in flight.
// An accepted cmd item passes the product, sum and rounding registers, then
// the output register, where rsp_valid rises. Throughput: one item per cycle
// while rsp_ready is high; four corner lanes of four 32x32 multipliers each
// work in parallel, so rect items run at the same rate as points.
// Pipeline: products, exact sums, rounding and clamping, merge into the
// output register.
// Reset: clears the pipeline and loads the identity matrix, zero offset.
// Stall: while rsp_ready is low the held result stays; the stages behind it
// keep filling until every stage holds an item, then cmd_ready falls.
// ----------------------------------------------------------------------------
module affine_2d_transform
	import af2d_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  af2d_cmd_t             cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output af2d_rsp_t             rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_W-1:0]    cfg_data
);

	af2d_cfg_t                   cfg_q;
	af2d_en_t                    en;
	logic                        v_s1, v_s2, v_s3, v_s4;
	af2d_cmd_t                   cmd_s1, cmd_s2, cmd_s3;
	af2d_lane_res_t [LANES-1:0]  lane_res;
	logic                        use_off, ceil_px;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx  <= COEF_ONE;
			cfg_q.coef_xy  <= '0;
			cfg_q.coef_yx  <= '0;
			cfg_q.coef_yy  <= COEF_ONE;
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (af2d_reg_e'(cfg_index))
				REG_COEF_XX:  cfg_q.coef_xx  <= cfg_data;
				REG_COEF_XY:  cfg_q.coef_xy  <= cfg_data;
				REG_COEF_YX:  cfg_q.coef_yx  <= cfg_data;
				REG_COEF_YY:  cfg_q.coef_yy  <= cfg_data;
				REG_OFFSET_X: cfg_q.offset_x <= cfg_data;
				REG_OFFSET_Y: cfg_q.offset_y <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when the next one moves on
	always_comb begin
		en.s4 = !v_s4 || rsp_ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign cmd_ready = en.s1;
	assign rsp_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= cmd_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) cmd_s1 <= cmd;
		if (en.s2) cmd_s2 <= cmd_s1;
		if (en.s3) cmd_s3 <= cmd_s2;
	end

	assign use_off = (cmd.opcode != OP_VECTOR);
	assign ceil_px = (cmd.opcode == OP_WINDOW);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		af2d_lane u_lane (
			.clk     (clk),
			.en      (en),
			.cfg     (cfg_q),
			.x       (CORNER_USE_QX[i] ? cmd.qx : cmd.px),
			.y       (CORNER_USE_QY[i] ? cmd.qy : cmd.py),
			.use_off (use_off),
			.ceil_px (ceil_px),
			.res     (lane_res[i])
		);
	end

	af2d_merge u_merge (
		.clk      (clk),
		.en       (en),
		.cmd      (cmd_s3),
		.lane_res (lane_res),
		.rsp      (rsp)
	);

	// no stall from the receiver means no stall at the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> cmd_ready)
		else $error("cmd_ready low while rsp_ready high");

	// a normal rectangle leaves as an ordered box
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s4 && v_s3 && cmd_s3.opcode == OP_RECT && !cmd_s3.rect_special)
		|=> (rsp.res_x <= rsp.res_x2 && rsp.res_y <= rsp.res_y2))
		else $error("bounding box not ordered");

	// second corner fields are zero outside rect mode
	a_x2_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s4 && v_s3 && cmd_s3.opcode != OP_RECT)
		|=> (rsp.res_x2 == '0 && rsp.res_y2 == '0))
		else $error("res_x2/res_y2 not zero outside rect mode");

	// a special rectangle never saturates
	a_special_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s4 && v_s3 && cmd_s3.opcode == OP_RECT && cmd_s3.rect_special)
		|=> !rsp.saturated)
		else $error("special rectangle flagged saturated");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D affine transform. Directed items hit each
// mode, tie rounding, pixel ceiling, clamping, special and unordered
// rectangles and writes to unused register indexes; then random items run
// under several matrix settings. Every result is checked against a local
// exact-arithmetic model of the map while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
	import af2d_pkg::*;

	localparam int WIDE       = 128;
	localparam int PIPE_DEPTH = 4;
	localparam int RAND_ITEMS = 400;
	localparam int RAND_SETS  = 8;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	localparam logic signed [COORD_W-1:0] CMAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;

	localparam logic signed [WIDE-1:0] WIDE_ONE = 1;
	localparam logic signed [WIDE-1:0] CLAMP_HI = (WIDE_ONE <<< (COORD_W - 1)) - 1;
	localparam logic signed [WIDE-1:0] CLAMP_LO = -(WIDE_ONE <<< (COORD_W - 1));

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	af2d_cmd_t             cmd       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	af2d_rsp_t             rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [COORD_W-1:0]    cfg_data  = '0;

	af2d_cfg_t  map_cfg;
	af2d_rsp_t  pending_results[$];
	int         errors          = 0;
	int         results_checked = 0;
	int         cfg_settings    = 0;
	int         op_count[4]     = '{0, 0, 0, 0};
	int         burst_left      = 0;
	int         stall_mode      = 0;
	int         mode_left       = 0;
	int         stall_tick      = 0;

	affine_2d_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
		$display("tb failed");
		$finish;
	end

	function automatic logic signed [COORD_W-1:0] map_row(
			input logic signed [COORD_W-1:0] c1, c2, x, y, off,
			input bit add_off, input bit to_pixel, inout bit clamped);
		logic signed [WIDE-1:0] w_c1, w_c2, w_x, w_y, w_off, sum;
		w_c1 = WIDE'(c1);
		w_c2 = WIDE'(c2);
		w_x = WIDE'(x);
		w_y = WIDE'(y);
		w_off = WIDE'(off);
		sum = w_c1 * w_x + w_c2 * w_y;
		if (add_off)
			sum = sum + (w_off <<< FRAC_BITS);
		if (to_pixel)
			sum = (sum + ((WIDE_ONE <<< (2 * FRAC_BITS)) - 1)) >>> (2 * FRAC_BITS);
		else
			sum = (sum + (WIDE_ONE <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (sum > CLAMP_HI) begin
			clamped = 1'b1;
			sum = CLAMP_HI;
		end else if (sum < CLAMP_LO) begin
			clamped = 1'b1;
			sum = CLAMP_LO;
		end
		return sum[COORD_W-1:0];
	endfunction

	function automatic af2d_rsp_t transform_item(input af2d_cmd_t c, input af2d_cfg_t m);
		af2d_rsp_t                  r;
		logic signed [COORD_W-1:0]  xs[4];
		logic signed [COORD_W-1:0]  ys[4];
		logic signed [COORD_W-1:0]  tx, ty, lo_x, hi_x, lo_y, hi_y;
		bit                         clamped;
		r = '0;
		clamped = 1'b0;
		lo_x = '0;
		hi_x = '0;
		lo_y = '0;
		hi_y = '0;
		case (c.opcode) inside
			OP_POINT, OP_VECTOR, OP_WINDOW: begin
				r.res_x = map_row(m.coef_xx, m.coef_xy, c.px, c.py, m.offset_x,
					c.opcode != OP_VECTOR, c.opcode == OP_WINDOW, clamped);
				r.res_y = map_row(m.coef_yx, m.coef_yy, c.px, c.py, m.offset_y,
					c.opcode != OP_VECTOR, c.opcode == OP_WINDOW, clamped);
			end
			default: begin
				if (c.rect_special) begin
					r.res_x = c.px;
					r.res_y = c.py;
					r.res_x2 = c.qx;
					r.res_y2 = c.qy;
				end else begin
					xs = '{c.px, c.qx, c.qx, c.px};
					ys = '{c.py, c.qy, c.py, c.qy};
					for (int i = 0; i < 4; i++) begin
						tx = map_row(m.coef_xx, m.coef_xy, xs[i], ys[i], m.offset_x,
							1'b1, 1'b0, clamped);
						ty = map_row(m.coef_yx, m.coef_yy, xs[i], ys[i], m.offset_y,
							1'b1, 1'b0, clamped);
						if (i == 0 || tx < lo_x) lo_x = tx;
						if (i == 0 || tx > hi_x) hi_x = tx;
						if (i == 0 || ty < lo_y) lo_y = ty;
						if (i == 0 || ty > hi_y) hi_y = ty;
					end
					r.res_x = lo_x;
					r.res_y = lo_y;
					r.res_x2 = hi_x;
					r.res_y2 = hi_y;
				end
			end
		endcase
		r.saturated = clamped;
		return r;
	endfunction

	function automatic af2d_cmd_t make_cmd(input af2d_op_e op,
			input logic signed [COORD_W-1:0] px, py, qx, qy, input logic special);
		af2d_cmd_t c;
		c.opcode = op;
		c.px = px;
		c.py = py;
		c.qx = qx;
		c.qy = qy;
		c.rect_special = special;
		return c;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			1: return ($signed($urandom_range(0, 4095)) - 2048) <<< FRAC_BITS;
			2: begin
				case ($urandom_range(0, 4))
					0: return CMAX;
					1: return CMIN;
					2: return '0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coef();
		return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
	endfunction

	function automatic af2d_cmd_t rand_item();
		af2d_cmd_t c;
		c.opcode = af2d_op_e'($urandom_range(0, 3));
		c.px = rand_coord();
		c.py = rand_coord();
		c.qx = rand_coord();
		c.qy = rand_coord();
		c.rect_special = (c.opcode == OP_RECT) ? ($urandom_range(0, 4) == 0)
			: 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic af2d_cfg_t rand_setting(input int kind);
		af2d_cfg_t m;
		case (kind)
			0: m = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef() <<< 6, rand_coef() <<< 6};
			1: m = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
			2: m = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
			3: m = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			4: m = '{'0, '0, '0, '0, rand_coord(), rand_coord()};
			default: m = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord()};
		endcase
		return m;
	endfunction

	task automatic send_item(input af2d_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		pending_results.push_back(transform_item(c, map_cfg));
		op_count[c.opcode]++;
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_COEF_XX:  map_cfg.coef_xx = val;
			REG_COEF_XY:  map_cfg.coef_xy = val;
			REG_COEF_YX:  map_cfg.coef_yx = val;
			REG_COEF_YY:  map_cfg.coef_yy = val;
			REG_OFFSET_X: map_cfg.offset_x = val;
			REG_OFFSET_Y: map_cfg.offset_y = val;
			default: ;
		endcase
	endtask

	task automatic load_setting(input af2d_cfg_t m, input bit spare_writes);
		drain();
		write_reg(REG_COEF_XX, m.coef_xx);
		write_reg(REG_COEF_XY, m.coef_xy);
		write_reg(REG_COEF_YX, m.coef_yx);
		write_reg(REG_COEF_YY, m.coef_yy);
		write_reg(REG_OFFSET_X, m.offset_x);
		write_reg(REG_OFFSET_Y, m.offset_y);
		if (spare_writes) begin
			write_reg(IDX_SPARE_LO, $urandom);
			write_reg(IDX_SPARE_HI, $urandom);
		end
		cfg_valid <= 1'b0;
		cfg_settings++;
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] exp_val,
			input logic [COORD_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s expected %h, actual %h", $time, name, exp_val, got_val);
			errors++;
		end
	endtask

	task automatic check_result(input af2d_rsp_t got);
		af2d_rsp_t exp_r;
		if (pending_results.size() == 0) begin
			$display("%0t: result with none expected, actual %h", $time, got);
			errors++;
		end else begin
			exp_r = pending_results.pop_front();
			check_field("res_x", exp_r.res_x, got.res_x);
			check_field("res_y", exp_r.res_y, got.res_y);
			check_field("res_x2", exp_r.res_x2, got.res_x2);
			check_field("res_y2", exp_r.res_y2, got.res_y2);
			check_field("saturated", COORD_W'(exp_r.saturated), COORD_W'(got.saturated));
			results_checked++;
		end
	endtask

	// result side: check accepted items, then pick the next stall state
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			stall_tick++;
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(0, 1));
				2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= (stall_tick % 5) != 0;
			endcase
		end
	end

	// identity matrix and zero offset straight out of reset
	task automatic test_reset_identity();
		send_item(make_cmd(OP_POINT, '0, '0, '0, '0, 1'b0));
		send_item(make_cmd(OP_POINT, CMAX, CMIN, '0, '0, 1'b0));
		send_item(make_cmd(OP_VECTOR, 32'sh0001_8000, -32'sh0002_4000, CMAX, CMIN, 1'b1));
	endtask

	// one item per mode; unused fields carry junk that must be ignored
	task automatic test_each_op();
		load_setting('{32'sh0002_0000, 32'sh0000_8000, -32'sh0000_c000, 32'sh0001_4000,
			32'sh000a_8000, -32'sh0003_4000}, 1'b0);
		send_item(make_cmd(OP_POINT, 32'sh0003_0000, -32'sh0001_2000, CMAX, CMIN, 1'b1));
		send_item(make_cmd(OP_VECTOR, -32'sh0007_0001, 32'sh0004_0003, CMIN, CMAX, 1'b1));
		send_item(make_cmd(OP_WINDOW, 32'sh0010_1234, 32'sh0020_5678, -1, 1, 1'b1));
		send_item(make_cmd(OP_RECT, -32'sh0002_0000, -32'sh0001_0000, 32'sh0005_0000,
			32'sh0003_8000, 1'b0));
	endtask

	// ties go toward plus infinity; window mode takes the ceiling
	task automatic test_rounding();
		load_setting('{32'sd1, '0, '0, -32'sd1, '0, '0}, 1'b0);
		send_item(make_cmd(OP_POINT, 32'sh0000_8000, 32'sh0000_8000, '0, '0, 1'b0));
		send_item(make_cmd(OP_POINT, -32'sh0000_8000, -32'sh0000_8000, '0, '0, 1'b0));
		load_setting('{COEF_ONE, '0, '0, COEF_ONE, '0, '0}, 1'b0);
		send_item(make_cmd(OP_WINDOW, 32'sh0003_0001, -32'sh0003_0001, '0, '0, 1'b0));
		send_item(make_cmd(OP_WINDOW, -32'sh0002_0000, 32'sh0000_ffff, '0, '0, 1'b0));
	endtask

	task automatic test_saturation();
		load_setting('{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}, 1'b0);
		send_item(make_cmd(OP_POINT, CMAX, CMAX, '0, '0, 1'b0));
		send_item(make_cmd(OP_WINDOW, CMIN, CMIN, '0, '0, 1'b0));
		send_item(make_cmd(OP_VECTOR, 32'sd1, 32'sd1, '0, '0, 1'b0));
		send_item(make_cmd(OP_RECT, CMIN, CMIN, CMAX, CMAX, 1'b0));
	endtask

	// quarter turn: ordered, unordered, degenerate and pass-through rectangles
	task automatic test_rect();
		load_setting('{'0, -COEF_ONE, COEF_ONE, '0, 32'sh0005_0000, -32'sh0005_0000}, 1'b0);
		send_item(make_cmd(OP_RECT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000,
			32'sh0006_0000, 1'b0));
		send_item(make_cmd(OP_RECT, 32'sh0009_0000, 32'sh0007_0000, -32'sh0003_0000,
			-32'sh0001_8000, 1'b0));
		send_item(make_cmd(OP_RECT, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
			32'sh0002_0000, 1'b0));
		send_item(make_cmd(OP_RECT, CMIN, CMAX, CMAX, CMIN, 1'b1));
	endtask

	// writes past the last register must leave the setting alone
	task automatic test_unused_index();
		drain();
		write_reg(IDX_SPARE_LO, $urandom);
		write_reg(IDX_SPARE_HI, $urandom);
		cfg_valid <= 1'b0;
		send_item(make_cmd(OP_POINT, 32'sh0001_0000, 32'sh0002_0000, '0, '0, 1'b0));
		send_item(make_cmd(OP_RECT, -32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000,
			-32'sh0004_0000, 1'b0));
	endtask

	task automatic test_random();
		int kind;
		for (int s = 0; s < RAND_SETS; s++) begin
			kind = (s < 5) ? s : $urandom_range(0, 5);
			load_setting(rand_setting(kind), 1'($urandom_range(0, 1)));
			for (int n = 0; n < RAND_ITEMS / RAND_SETS; n++)
				send_item(rand_item());
		end
	endtask

	initial begin
		map_cfg = '{COEF_ONE, '0, '0, COEF_ONE, '0, '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_each_op();
		test_rounding();
		test_saturation();
		test_rect();
		test_unused_index();
		test_random();
		drain();
		$display("items sent: %0d point, %0d vector, %0d window, %0d rect",
			op_count[OP_POINT], op_count[OP_VECTOR], op_count[OP_WINDOW], op_count[OP_RECT]);
		$display("%0d results checked over %0d register settings, %0d mismatches",
			results_checked, cfg_settings, errors);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
